>>> rtl/core/sba_pkg.sv
// ----------------------------------------------------------------------------
// sba_pkg
// Shared types, codes and reset values of the snooping bus arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package sba_pkg;

  // Parameter defaults
  localparam int MAX_PROCS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int ADDR_BITS_DEF   = 48;

  // Fixed field widths
  localparam int TYPE_W    = 3;
  localparam int PROC_W    = 3;
  localparam int KIND_W    = 3;
  localparam int MSG_W     = 2;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int PCNT_W    = 4;
  localparam int IDX_W     = 5;

  typedef logic [PROC_W-1:0] proc_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [MSG_W-1:0]  msg_t;

  // Input transaction codes
  localparam logic [TYPE_W-1:0] REQ_TICK    = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_BUS_RD  = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_BUS_RDX = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_DATA    = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_SHARED  = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_MEM_RDY = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_QUERY   = 3'd6;
  localparam logic [TYPE_W-1:0] REQ_NOP     = 3'd7;

  // Result kinds
  localparam kind_t KIND_MEM_RD = 3'd0;
  localparam kind_t KIND_SNOOP  = 3'd1;
  localparam kind_t KIND_DONE   = 3'd2;
  localparam kind_t KIND_QUERY  = 3'd3;
  localparam kind_t KIND_DROP   = 3'd4;

  // Message types
  localparam msg_t MSG_BUS_RD  = 2'd0;
  localparam msg_t MSG_BUS_RDX = 2'd1;
  localparam msg_t MSG_DATA    = 2'd2;
  localparam msg_t MSG_SHARED  = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROC_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_DLY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_XFER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_LAT    = 2'd3;

  // Register reset values
  localparam logic [PCNT_W-1:0] PROC_COUNT_RST = 4'd1;
  localparam logic [CFG_W-1:0]  CACHE_DLY_RST  = 16'd10;
  localparam logic [CFG_W-1:0]  CACHE_XFER_RST = 16'd10;
  localparam logic [CFG_W-1:0]  MEM_LAT_RST    = 16'd100;

  // Pending transaction phases
  localparam logic [1:0] PH_WAIT_CACHE = 2'd0;
  localparam logic [1:0] PH_WAIT_MEM   = 2'd1;
  localparam logic [1:0] PH_CACHE_XFER = 2'd2;
  localparam logic [1:0] PH_MEM_XFER   = 2'd3;

  // Classified operation
  typedef enum logic [2:0] {
    OP_TICK, OP_BUS_RD, OP_BUS_RDX, OP_DATA, OP_SHARED, OP_MEM_RDY, OP_QUERY
  } op_t;

  typedef struct packed {
    op_t   op;
    proc_t proc;
  } item_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/sba_ram.sv
// ----------------------------------------------------------------------------
// sba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/sba_front.sv
// ----------------------------------------------------------------------------
// sba_front
// Accepts input transactions, classifies them and buffers them in a
// two-entry queue toward the bus engine. No-operation codes are consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module sba_front #(
  parameter int ADDR_BITS = sba_pkg::ADDR_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [sba_pkg::TYPE_W-1:0]   req_type,
  input  wire logic [ADDR_BITS-1:0]         addr,
  input  wire sba_pkg::proc_t               proc,
  output logic                              q_valid,
  input  wire logic                         q_ready,
  output sba_pkg::item_ctl_t                q_ctl,
  output logic      [ADDR_BITS-1:0]         q_addr
);

  sba_pkg::item_ctl_t   ctl_buf  [2];
  logic [ADDR_BITS-1:0] addr_buf [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;
  sba_pkg::op_t         op_cls;
  logic                 push;
  logic                 pop;

  // Classify the raw code
  always_comb begin
    unique case (req_type)
      sba_pkg::REQ_TICK:    op_cls = sba_pkg::OP_TICK;
      sba_pkg::REQ_BUS_RD:  op_cls = sba_pkg::OP_BUS_RD;
      sba_pkg::REQ_BUS_RDX: op_cls = sba_pkg::OP_BUS_RDX;
      sba_pkg::REQ_DATA:    op_cls = sba_pkg::OP_DATA;
      sba_pkg::REQ_SHARED:  op_cls = sba_pkg::OP_SHARED;
      sba_pkg::REQ_MEM_RDY: op_cls = sba_pkg::OP_MEM_RDY;
      sba_pkg::REQ_QUERY:   op_cls = sba_pkg::OP_QUERY;
      default:              op_cls = sba_pkg::OP_TICK;
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready && (req_type != sba_pkg::REQ_NOP);
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_ctl    = ctl_buf[rd_ptr];
  assign q_addr   = addr_buf[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      ctl_buf[wr_ptr]  <= '{op: op_cls, proc: proc};
      addr_buf[wr_ptr] <= addr;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sba_back.sv
// ----------------------------------------------------------------------------
// sba_back
// Bus engine: holds the pending transaction and the per-processor request
// FIFOs, runs ticks, snoop fan-out and round-robin arbitration, and drives
// the registered result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sba_back #(
  parameter int MAX_PROCS   = sba_pkg::MAX_PROCS_DEF,
  parameter int QUEUE_DEPTH = sba_pkg::QUEUE_DEPTH_DEF,
  parameter int ADDR_BITS   = sba_pkg::ADDR_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [sba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sba_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic                            q_valid,
  output logic                                 q_ready,
  input  wire sba_pkg::item_ctl_t              q_ctl,
  input  wire logic [ADDR_BITS-1:0]            q_addr,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output sba_pkg::kind_t                       kind,
  output sba_pkg::msg_t                        msg_type,
  output logic      [ADDR_BITS-1:0]            addr_res,
  output sba_pkg::proc_t                       target_proc,
  output logic                                 flag,
  output logic                                 last
);

  localparam int PW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOTS = MAX_PROCS * QUEUE_DEPTH;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW    = ADDR_BITS + 1;
  localparam sba_pkg::idx_t MAXC   = sba_pkg::idx_t'(MAX_PROCS);
  localparam logic [CW-1:0] QD     = CW'(QUEUE_DEPTH);
  localparam logic [HW:0]   QD_EXT = (HW+1)'(QUEUE_DEPTH);
  localparam logic [HW-1:0] HLAST  = HW'(QUEUE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_ARB, S_ARB_LOAD, S_MEMRD, S_SNOOP
  } state_t;

  state_t state;

  // Configuration registers
  logic [sba_pkg::PCNT_W-1:0] proc_count;
  logic [sba_pkg::CFG_W-1:0]  snoop_wait;
  logic [sba_pkg::CFG_W-1:0]  cache_xfer;
  logic [sba_pkg::CFG_W-1:0]  mem_lat;

  // Pending transaction
  logic                      pend_valid;
  logic                      pend_rdx;
  logic [ADDR_BITS-1:0]      pend_addr;
  sba_pkg::idx_t             pend_proc;
  logic [1:0]                pend_phase;
  logic                      flag_shared;
  logic                      flag_memrdy;
  logic [sba_pkg::CFG_W-1:0] countdown;
  sba_pkg::idx_t             rr;

  // Current transaction
  sba_pkg::op_t              cur_op;
  logic [ADDR_BITS-1:0]      cur_addr;
  sba_pkg::idx_t             cur_pn;

  // Arbitration and fan-out
  sba_pkg::idx_t             pos;
  sba_pkg::idx_t             scan;
  sba_pkg::idx_t             sidx;

  // Per-processor FIFO pointers
  logic [HW-1:0] head [MAX_PROCS];
  logic [CW-1:0] qcnt [MAX_PROCS];

  sba_pkg::idx_t             cnt;
  logic                      out_free;
  logic                      out_load;
  logic                      match;
  logic [sba_pkg::CFG_W-1:0] cd_dec;
  logic [sba_pkg::CFG_W-1:0] cd_t;
  logic [1:0]                phase_t;
  logic [PW-1:0]             idx_sel;
  logic [HW-1:0]             sel_head;
  logic [CW-1:0]             sel_cnt;
  logic [HW:0]               slot_sum;
  logic [HW-1:0]             slot;
  logic [HW-1:0]             head_inc;
  logic                      is_rdx;
  logic                      req_drop;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [AW-1:0]             ram_raddr;
  logic [EW-1:0]             ram_rdata;
  sba_pkg::idx_t             pos_inc;
  sba_pkg::idx_t             snoop_first;
  sba_pkg::idx_t             snoop_nxt;

  // Reduce v modulo c for small v, c >= 1
  function automatic sba_pkg::idx_t mod_cnt(input sba_pkg::idx_t v, input sba_pkg::idx_t c);
    sba_pkg::idx_t r;
    r = v;
    for (int k = 0; k < MAX_PROCS; k++) begin
      if (r >= c) r = r - c;
    end
    return r;
  endfunction

  // Skip the requester in the snoop walk
  function automatic sba_pkg::idx_t skip_req(input sba_pkg::idx_t j, input sba_pkg::idx_t rq);
    return (j == rq) ? j + sba_pkg::idx_t'(1) : j;
  endfunction

  // Effective processor count, clamped to 1..MAX_PROCS
  always_comb begin
    if (proc_count == '0) cnt = sba_pkg::idx_t'(1);
    else if (sba_pkg::idx_t'(proc_count) > MAXC) cnt = MAXC;
    else cnt = sba_pkg::idx_t'(proc_count);
  end

  assign out_free = !out_valid || out_ready;
  assign match    = pend_valid && (pend_addr == cur_addr);
  assign q_ready  = (state == S_IDLE);

  // Tick countdown step
  assign cd_dec  = (countdown != '0) ? countdown - 1'b1 : '0;
  assign cd_t    = flag_memrdy ? '0 : cd_dec;
  assign phase_t = flag_memrdy ? sba_pkg::PH_MEM_XFER : pend_phase;

  // FIFO pointer access: arbitration position or current requester
  assign idx_sel  = (state == S_ARB) ? pos[PW-1:0] : cur_pn[PW-1:0];
  assign sel_head = head[idx_sel];
  assign sel_cnt  = qcnt[idx_sel];
  assign slot_sum = (HW+1)'(sel_head) + (HW+1)'(sel_cnt);
  assign slot     = (slot_sum >= QD_EXT) ? HW'(slot_sum - QD_EXT) : HW'(slot_sum);
  assign head_inc = (sel_head == HLAST) ? '0 : sel_head + 1'b1;

  assign is_rdx   = (cur_op == sba_pkg::OP_BUS_RDX);
  assign req_drop = (cur_pn >= cnt) || (pend_valid && (sel_cnt >= QD));
  assign ram_we   = (state == S_EXEC) && (cur_op == sba_pkg::OP_BUS_RD ||
                    cur_op == sba_pkg::OP_BUS_RDX) && !req_drop && pend_valid;
  assign ram_waddr = AW'(int'(idx_sel) * QUEUE_DEPTH + int'(slot));
  assign ram_raddr = AW'(int'(idx_sel) * QUEUE_DEPTH + int'(sel_head));

  assign pos_inc     = (pos + sba_pkg::idx_t'(1) == cnt) ? '0 : pos + sba_pkg::idx_t'(1);
  assign snoop_first = skip_req('0, pend_proc);
  assign snoop_nxt   = skip_req(sidx + sba_pkg::idx_t'(1), pend_proc);

  // Result register loads this cycle
  assign out_load = out_free && (
    (state == S_MEMRD) || (state == S_SNOOP) ||
    ((state == S_EXEC) && (
      (cur_op == sba_pkg::OP_QUERY) ||
      ((cur_op == sba_pkg::OP_BUS_RD || cur_op == sba_pkg::OP_BUS_RDX) && req_drop) ||
      ((cur_op == sba_pkg::OP_TICK) && pend_valid && (cd_t == '0) &&
       (phase_t == sba_pkg::PH_CACHE_XFER || phase_t == sba_pkg::PH_MEM_XFER)))));

  // Queued request store
  sba_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({is_rdx, cur_addr}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      proc_count <= sba_pkg::PROC_COUNT_RST;
      snoop_wait <= sba_pkg::CACHE_DLY_RST;
      cache_xfer <= sba_pkg::CACHE_XFER_RST;
      mem_lat    <= sba_pkg::MEM_LAT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sba_pkg::CFG_PROC_COUNT: proc_count <= cfg_data[sba_pkg::PCNT_W-1:0];
        sba_pkg::CFG_CACHE_DLY:  snoop_wait <= cfg_data;
        sba_pkg::CFG_CACHE_XFER: cache_xfer <= cfg_data;
        sba_pkg::CFG_MEM_LAT:    mem_lat    <= cfg_data;
      endcase
    end
  end

  // Engine state machine and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pend_valid  <= 1'b0;
      pend_rdx    <= 1'b0;
      pend_addr   <= '0;
      pend_proc   <= '0;
      pend_phase  <= sba_pkg::PH_WAIT_CACHE;
      flag_shared <= 1'b0;
      flag_memrdy <= 1'b0;
      countdown   <= '0;
      rr          <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < MAX_PROCS; i++) begin
        head[i] <= '0;
        qcnt[i] <= '0;
      end
    end else begin
      // held while stalled, cleared once taken, set on a new result
      out_valid <= out_load || (out_valid && !out_ready);

      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur_op   <= q_ctl.op;
            cur_addr <= q_addr;
            cur_pn   <= sba_pkg::idx_t'(q_ctl.proc);
            state    <= S_EXEC;
          end
        end

        S_EXEC: begin
          unique case (cur_op)
            sba_pkg::OP_TICK: begin
              if (!pend_valid) begin
                pos   <= mod_cnt(rr, cnt);
                scan  <= '0;
                state <= S_ARB;
              end else if (cd_t != '0) begin
                countdown <= cd_t;
                state     <= S_IDLE;
              end else if (phase_t == sba_pkg::PH_WAIT_CACHE) begin
                countdown  <= mem_lat;
                pend_phase <= sba_pkg::PH_WAIT_MEM;
                state      <= S_MEMRD;
              end else if (phase_t == sba_pkg::PH_WAIT_MEM) begin
                countdown <= '0;
                state     <= S_IDLE;
              end else if (out_free) begin
                // completion, Shared if a shared reply was seen
                kind        <= sba_pkg::KIND_DONE;
                msg_type    <= flag_shared ? sba_pkg::MSG_SHARED : sba_pkg::MSG_DATA;
                addr_res    <= pend_addr;
                target_proc <= sba_pkg::proc_t'(pend_proc);
                flag        <= 1'b0;
                last        <= 1'b1;
                pend_valid  <= 1'b0;
                pend_phase  <= sba_pkg::PH_WAIT_CACHE;
                flag_shared <= 1'b0;
                flag_memrdy <= 1'b0;
                countdown   <= '0;
                state       <= S_IDLE;
              end
            end

            sba_pkg::OP_BUS_RD, sba_pkg::OP_BUS_RDX: begin
              if (req_drop) begin
                if (out_free) begin
                  kind        <= sba_pkg::KIND_DROP;
                  msg_type    <= is_rdx ? sba_pkg::MSG_BUS_RDX : sba_pkg::MSG_BUS_RD;
                  addr_res    <= cur_addr;
                  target_proc <= sba_pkg::proc_t'(cur_pn);
                  flag        <= 1'b0;
                  last        <= 1'b1;
                  state       <= S_IDLE;
                end
              end else if (!pend_valid) begin
                pend_valid  <= 1'b1;
                pend_rdx    <= is_rdx;
                pend_addr   <= cur_addr;
                pend_proc   <= cur_pn;
                pend_phase  <= sba_pkg::PH_WAIT_CACHE;
                flag_shared <= 1'b0;
                flag_memrdy <= 1'b0;
                countdown   <= snoop_wait;
                state       <= S_IDLE;
              end else begin
                qcnt[idx_sel] <= sel_cnt + 1'b1;
                state         <= S_IDLE;
              end
            end

            sba_pkg::OP_DATA: begin
              if (match) begin
                pend_phase <= sba_pkg::PH_CACHE_XFER;
                countdown  <= cache_xfer;
              end
              state <= S_IDLE;
            end

            sba_pkg::OP_SHARED: begin
              if (match) flag_shared <= 1'b1;
              state <= S_IDLE;
            end

            sba_pkg::OP_MEM_RDY: begin
              if (match && pend_proc == cur_pn) flag_memrdy <= 1'b1;
              state <= S_IDLE;
            end

            sba_pkg::OP_QUERY: begin
              if (out_free) begin
                kind        <= sba_pkg::KIND_QUERY;
                msg_type    <= sba_pkg::MSG_BUS_RD;
                addr_res    <= cur_addr;
                target_proc <= sba_pkg::proc_t'(cur_pn);
                flag        <= match && (pend_proc == cur_pn) &&
                               (pend_phase == sba_pkg::PH_CACHE_XFER);
                last        <= 1'b1;
                state       <= S_IDLE;
              end
            end

            default: state <= S_IDLE;
          endcase
        end

        // Round-robin walk, one processor per cycle
        S_ARB: begin
          if (sel_cnt != '0) begin
            head[idx_sel] <= head_inc;
            qcnt[idx_sel] <= sel_cnt - 1'b1;
            rr            <= pos_inc;
            pend_proc     <= pos;
            state         <= S_ARB_LOAD;
          end else if (scan + sba_pkg::idx_t'(1) == cnt) begin
            state <= S_IDLE;
          end else begin
            pos  <= pos_inc;
            scan <= scan + sba_pkg::idx_t'(1);
          end
        end

        S_ARB_LOAD: begin
          pend_valid  <= 1'b1;
          pend_rdx    <= ram_rdata[ADDR_BITS];
          pend_addr   <= ram_rdata[ADDR_BITS-1:0];
          pend_phase  <= sba_pkg::PH_WAIT_CACHE;
          flag_shared <= 1'b0;
          flag_memrdy <= 1'b0;
          countdown   <= snoop_wait;
          state       <= S_IDLE;
        end

        S_MEMRD: begin
          if (out_free) begin
            kind        <= sba_pkg::KIND_MEM_RD;
            msg_type    <= pend_rdx ? sba_pkg::MSG_BUS_RDX : sba_pkg::MSG_BUS_RD;
            addr_res    <= pend_addr;
            target_proc <= sba_pkg::proc_t'(pend_proc);
            flag        <= 1'b0;
            last        <= (snoop_first >= cnt);
            sidx        <= snoop_first;
            state       <= (snoop_first >= cnt) ? S_IDLE : S_SNOOP;
          end
        end

        // Snoop fan-out, one processor per result
        S_SNOOP: begin
          if (out_free) begin
            kind        <= sba_pkg::KIND_SNOOP;
            msg_type    <= pend_rdx ? sba_pkg::MSG_BUS_RDX : sba_pkg::MSG_BUS_RD;
            addr_res    <= pend_addr;
            target_proc <= sba_pkg::proc_t'(sidx);
            flag        <= 1'b0;
            last        <= (snoop_nxt >= cnt);
            sidx        <= snoop_nxt;
            if (snoop_nxt >= cnt) state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/snooping_bus_arbiter.sv
// A transaction passes through the front queue and then the engine; results
// leave through one output register. The engine takes a new transaction only
// when back in its idle state; a tick that issues the memory read sends that result
// and then one snoop result to each other active processor, and an arbitration tick
// probes the processor FIFOs in round-robin order, one FIFO probed per cycle.
// Reset: synchronous; all FIFOs empty, no pending transaction, registers at defaults.
// ----------------------------------------------------------------------------
// snooping_bus_arbiter
// Snooping bus controller with one transaction in flight, per-processor
// request FIFOs and round-robin arbitration.
// ----------------------------------------------------------------------------
`default_nettype none

module snooping_bus_arbiter #(
  parameter int MAX_PROCS   = sba_pkg::MAX_PROCS_DEF,
  parameter int QUEUE_DEPTH = sba_pkg::QUEUE_DEPTH_DEF,
  parameter int ADDR_BITS   = sba_pkg::ADDR_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [sba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sba_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [sba_pkg::TYPE_W-1:0]    req_type,
  input  wire logic [ADDR_BITS-1:0]          addr,
  input  wire sba_pkg::proc_t                proc,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output sba_pkg::kind_t                     kind,
  output sba_pkg::msg_t                      msg_type,
  output logic      [ADDR_BITS-1:0]          addr_res,
  output sba_pkg::proc_t                     target_proc,
  output logic                               flag,
  output logic                               last
);

  logic                 q_valid;
  logic                 q_ready;
  sba_pkg::item_ctl_t   q_ctl;
  logic [ADDR_BITS-1:0] q_addr;

  // Intake and classification
  sba_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .addr     (addr),
    .proc     (proc),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_ctl    (q_ctl),
    .q_addr   (q_addr)
  );

  // Bus engine
  sba_back #(
    .MAX_PROCS   (MAX_PROCS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ADDR_BITS   (ADDR_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_ctl       (q_ctl),
    .q_addr      (q_addr),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .msg_type    (msg_type),
    .addr_res    (addr_res),
    .target_proc (target_proc),
    .flag        (flag),
    .last        (last)
  );

endmodule

`default_nettype wire

>>> rtl/core/sba_checker.sv
// ----------------------------------------------------------------------------
// sba_checker
// Port-level checks on the result channel of the snooping bus arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

module sba_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire sba_pkg::kind_t kind,
  input wire logic           flag,
  input wire logic           last
);

  // A stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // Only defined result kinds
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == sba_pkg::KIND_MEM_RD || kind == sba_pkg::KIND_SNOOP ||
                   kind == sba_pkg::KIND_DONE || kind == sba_pkg::KIND_QUERY ||
                   kind == sba_pkg::KIND_DROP))
    else $error("undefined result kind");

  // Flag is carried only by query answers
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != sba_pkg::KIND_QUERY |-> !flag)
    else $error("flag set outside a query answer");

  // Drops, queries and completions are single results
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == sba_pkg::KIND_DROP || kind == sba_pkg::KIND_QUERY ||
                  kind == sba_pkg::KIND_DONE) |-> last)
    else $error("single result without last");

  // Output register empties on reset
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind snooping_bus_arbiter sba_checker u_sba_checker (.*);

`default_nettype wire
